// File: sv/wdrc_pkg.sv
// Shared constants and types for the counting-RAM discriminator.
package wdrc_pkg;

    localparam int RAM_COUNT  = 64;
    localparam int ADDR_BITS  = 8;
    localparam int COUNT_BITS = 16;

    localparam int RAM_BITS   = $clog2(RAM_COUNT);
    localparam int CELL_BITS  = RAM_BITS + ADDR_BITS;
    localparam int DEPTH      = RAM_COUNT * (1 << ADDR_BITS);

    localparam int RC_BITS    = 7;
    localparam int HIT_BITS   = 7;
    localparam int OUT_VAL_BITS = 16;
    localparam int OUT_RAM_BITS = 6;
    localparam int TRAIN_BITS = 32;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [HIT_BITS-1:0]   HIT_MAX   = {HIT_BITS{1'b1}};
    localparam logic [TRAIN_BITS-1:0] TRAIN_MAX = {TRAIN_BITS{1'b1}};
    localparam logic [RC_BITS-1:0]    RC_RESET  = RC_BITS'(RAM_COUNT);

    typedef enum logic [1:0] {
        REQ_TRAIN    = 2'd0,
        REQ_CLASSIFY = 2'd1,
        REQ_RESPONSE = 2'd2
    } req_t;

    typedef enum logic {
        KIND_SCORE    = 1'b0,
        KIND_RESPONSE = 1'b1
    } kind_t;

endpackage

// File: sv/wisard_discriminator_ram_counters.sv
// Top level: counting-RAM discriminator with one read-modify-write memory.
// Each item passes the read stage and the modify stage, and its result is registered into the output registers.
// Throughput: one item per cycle while busy is low; the single-port-per-direction counter memory sets this,
// with a back-to-back write to the same cell forwarded into the following read.
// Reset: a clearing pass zeroes all 16384 counters, one per cycle; busy is high from reset
// until the pass has written the last counter. The receiver cannot stall; done pulses for one cycle.
module wisard_discriminator_ram_counters (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [7:0]  tuple_address,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_data,
    output logic        done,
    output logic        result_kind,
    output logic [6:0]  hit_count,
    output logic [15:0] cell_value,
    output logic [5:0]  ram_index,
    output logic        is_last,
    output logic [31:0] training_count
);

    // counter memory
    logic [wdrc_pkg::COUNT_BITS-1:0] mem [wdrc_pkg::DEPTH];
    logic [wdrc_pkg::COUNT_BITS-1:0] rd_data_reg;

    // clearing pass
    logic [wdrc_pkg::CELL_BITS-1:0] clr_idx_reg, clr_idx_next;
    logic                           clr_done_reg, clr_done_next;

    // configuration and sequencing state
    logic [wdrc_pkg::RC_BITS-1:0]    ram_count_reg, ram_count_next;
    logic [wdrc_pkg::RAM_BITS-1:0]   cur_ram_reg, cur_ram_next;
    logic [wdrc_pkg::HIT_BITS-1:0]   hit_acc_reg, hit_acc_next;
    logic [wdrc_pkg::TRAIN_BITS-1:0] trains_reg, trains_next;
    logic [wdrc_pkg::RC_BITS-1:0]    last_idx;
    logic                            accept;
    logic                            in_last;
    logic                            op_valid;

    // read stage
    logic                            s1_valid_reg, s1_valid_next;
    logic [1:0]                      s1_op_reg;
    logic [wdrc_pkg::RAM_BITS-1:0]   s1_ram_reg;
    logic                            s1_last_reg;
    logic [wdrc_pkg::CELL_BITS-1:0]  s1_cell_reg;
    logic [wdrc_pkg::CELL_BITS-1:0]  rd_addr;

    // forwarding of the previous write
    logic                            fwd_valid_reg;
    logic [wdrc_pkg::CELL_BITS-1:0]  fwd_cell_reg;
    logic [wdrc_pkg::COUNT_BITS-1:0] fwd_data_reg;

    // modify stage
    logic [wdrc_pkg::COUNT_BITS-1:0] value;
    logic                            mem_we;
    logic [wdrc_pkg::CELL_BITS-1:0]  mem_waddr;
    logic [wdrc_pkg::COUNT_BITS-1:0] mem_wdata;
    logic [wdrc_pkg::HIT_BITS-1:0]   hit_sum;
    logic                            res_fire;
    logic                            res_kind;
    logic [wdrc_pkg::OUT_VAL_BITS-1:0] res_value;

    // output registers
    logic                              done_reg;
    logic                              kind_reg;
    logic [wdrc_pkg::HIT_BITS-1:0]     hit_out_reg;
    logic [wdrc_pkg::OUT_VAL_BITS-1:0] value_out_reg;
    logic [wdrc_pkg::OUT_RAM_BITS-1:0] ram_out_reg;
    logic                              last_out_reg;
    logic [wdrc_pkg::TRAIN_BITS-1:0]   train_out_reg;

    assign busy     = !clr_done_reg;
    assign accept   = start && !busy;
    assign op_valid = (req_type == wdrc_pkg::REQ_TRAIN) ||
                      (req_type == wdrc_pkg::REQ_CLASSIFY) ||
                      (req_type == wdrc_pkg::REQ_RESPONSE);

    // clamp ram_count into 1..RAM_COUNT and take the last index
    always_comb
    begin
        if (ram_count_reg == '0)
            last_idx = '0;
        else if (ram_count_reg > wdrc_pkg::RC_BITS'(wdrc_pkg::RAM_COUNT))
            last_idx = wdrc_pkg::RC_BITS'(wdrc_pkg::RAM_COUNT - 1);
        else
            last_idx = ram_count_reg - wdrc_pkg::RC_BITS'(1);
    end

    assign in_last = (wdrc_pkg::RC_BITS'(cur_ram_reg) == last_idx);
    assign rd_addr = {cur_ram_reg, tuple_address[wdrc_pkg::ADDR_BITS-1:0]};

    // modify stage: forward a write that lands on the same edge as this read
    always_comb
    begin
        value = (fwd_valid_reg && fwd_cell_reg == s1_cell_reg) ? fwd_data_reg : rd_data_reg;

        mem_we    = 1'b0;
        mem_waddr = s1_cell_reg;
        mem_wdata = value;
        hit_sum   = hit_acc_reg;
        hit_acc_next = hit_acc_reg;
        trains_next  = trains_reg;
        res_fire  = 1'b0;
        res_kind  = wdrc_pkg::KIND_SCORE;
        res_value = '0;

        if (!clr_done_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end
        else if (s1_valid_reg)
        begin
            case (s1_op_reg)
                wdrc_pkg::REQ_TRAIN:
                begin
                    mem_we = 1'b1;
                    if (value != wdrc_pkg::COUNT_MAX)
                        mem_wdata = value + wdrc_pkg::COUNT_BITS'(1);
                    if (s1_ram_reg == '0 && trains_reg != wdrc_pkg::TRAIN_MAX)
                        trains_next = trains_reg + wdrc_pkg::TRAIN_BITS'(1);
                end
                wdrc_pkg::REQ_CLASSIFY:
                begin
                    if (value != '0 && hit_acc_reg != wdrc_pkg::HIT_MAX)
                        hit_sum = hit_acc_reg + wdrc_pkg::HIT_BITS'(1);
                    res_fire = s1_last_reg;
                    res_kind = wdrc_pkg::KIND_SCORE;
                end
                wdrc_pkg::REQ_RESPONSE:
                begin
                    res_fire = 1'b1;
                    res_kind = wdrc_pkg::KIND_RESPONSE;
                    res_value = wdrc_pkg::OUT_VAL_BITS'(value);
                end
                default:
                begin
                    res_fire = 1'b0;
                end
            endcase
            hit_acc_next = s1_last_reg ? '0 : hit_sum;
        end

        // a configuration write starts a new tuple
        if (cfg_we)
            hit_acc_next = '0;
    end

    always_comb
    begin
        ram_count_next = ram_count_reg;
        cur_ram_next   = cur_ram_reg;
        s1_valid_next  = accept && op_valid;
        if (accept && op_valid)
            cur_ram_next = in_last ? '0 : cur_ram_reg + wdrc_pkg::RAM_BITS'(1);
        if (cfg_we)
        begin
            ram_count_next = cfg_data;
            cur_ram_next   = '0;
        end

        clr_idx_next  = clr_idx_reg;
        clr_done_next = clr_done_reg;
        if (!clr_done_reg)
        begin
            clr_idx_next = clr_idx_reg + wdrc_pkg::CELL_BITS'(1);
            if (clr_idx_reg == wdrc_pkg::CELL_BITS'(wdrc_pkg::DEPTH - 1))
                clr_done_next = 1'b1;
        end
    end

    // memory: registered read, one write per cycle
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg   <= '0;
            clr_done_reg  <= 1'b0;
            ram_count_reg <= wdrc_pkg::RC_RESET;
            cur_ram_reg   <= '0;
            hit_acc_reg   <= '0;
            trains_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            clr_idx_reg   <= clr_idx_next;
            clr_done_reg  <= clr_done_next;
            ram_count_reg <= ram_count_next;
            cur_ram_reg   <= cur_ram_next;
            hit_acc_reg   <= hit_acc_next;
            trains_reg    <= trains_next;
            s1_valid_reg  <= s1_valid_next;
            fwd_valid_reg <= mem_we && clr_done_reg;
            done_reg      <= res_fire;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_op_reg     <= req_type;
        s1_ram_reg    <= cur_ram_reg;
        s1_last_reg   <= in_last;
        s1_cell_reg   <= rd_addr;
        fwd_cell_reg  <= mem_waddr;
        fwd_data_reg  <= mem_wdata;
        kind_reg      <= res_kind;
        hit_out_reg   <= (res_kind == wdrc_pkg::KIND_SCORE) ? hit_sum : '0;
        value_out_reg <= res_value;
        ram_out_reg   <= wdrc_pkg::OUT_RAM_BITS'(s1_ram_reg);
        last_out_reg  <= s1_last_reg;
        train_out_reg <= trains_next;
    end

    assign done           = done_reg;
    assign result_kind    = kind_reg;
    assign hit_count      = hit_out_reg;
    assign cell_value     = value_out_reg;
    assign ram_index      = ram_out_reg;
    assign is_last        = last_out_reg;
    assign training_count = train_out_reg;

    a_done_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(s1_valid_reg))
        else $error("result without an item in the modify stage");

    a_score_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result_kind == wdrc_pkg::KIND_SCORE) |-> is_last)
        else $error("score emitted before the last RAM");

    a_ram_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wdrc_pkg::RC_BITS'(cur_ram_reg) <= last_idx)
        else $error("RAM index beyond the RAMs in use");

    a_no_items_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_done_reg |=> !s1_valid_reg)
        else $error("item entered during the clearing pass");

    a_train_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> trains_reg >= $past(trains_reg))
        else $error("training count went down");

endmodule
